### hdl/textured_wall_column_renderer_defines.svh
// Assertion macros for the textured wall column renderer.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TEXTURED_WALL_COLUMN_RENDERER_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_RENDERER_DEFINES_SVH

// Plain property, checked outside reset
`define TWCR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication into the next cycle, checked outside reset
`define TWCR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/twcr_pkg.sv
// Shared constants and types for the textured wall column renderer.
// No dependencies.
`default_nettype none

package twcr_pkg;

  // Screen and texture geometry
  localparam int unsigned SCREEN_ROWS  = 64;
  localparam int unsigned HALF_ROWS    = SCREEN_ROWS / 2;
  localparam int unsigned ROW_W        = 6;
  localparam int unsigned COL_W        = 7;
  localparam int unsigned TEX_COL_W    = 6;
  localparam int unsigned TEX_ROW_W    = 6;
  localparam int unsigned TILE_W       = 3;
  localparam int unsigned STORE_DEPTH  = 32768;
  localparam int unsigned ADDR_W       = 15;
  localparam int unsigned COLOR_W      = 32;
  localparam logic [COLOR_W-1:0] SHADE_MASK = 32'h007F_7F7F;

  // Slice numerator: rows * 256
  localparam int unsigned SLICE_NUM    = SCREEN_ROWS * 256;
  // Per-row step of the scaled row numerator (2 rows * 32)
  localparam int unsigned ROW_STEP     = 64;

  // Divider sizing
  localparam int unsigned DIV_W        = 23;
  localparam int unsigned DSR_W        = 16;
  localparam int unsigned DIV_CNT_W    = 5;

  // Command codes (tuser)
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

### hdl/textured_wall_column_renderer.sv
// Textured wall column renderer: top level, sequencer and pixel output stage.
// Depends on twcr_pkg, twcr_ram, twcr_div and the assertion macro header.
//
// Usage:
// - Input channel s_axis_*: tuser selects the command. A load request writes one
//   texel word into the 32768-entry texture store and produces nothing. A render
//   request takes one ray hit and produces one pixel request per screen row of
//   the wall slice on m_axis_*, top row first, tlast on the final pixel.
// - A render runs up to three divider passes (slice height, skipped for a zero
//   distance; per-row step; first texture row) plus setup, and then one pixel
//   per cycle while the output is not stalled, set by the single texture read
//   port. A full column has 63 pixels.
// - A new request is taken once the previous one's last texture read has
//   moved into the output register, where that pixel may still sit.
// - While m_axis_tready is low a valid output register holds, and texture
//   reads stall once one is pending.
// - Reset clears the control state only; the texture store holds undefined data
//   until written.
`include "textured_wall_column_renderer_defines.svh"
`default_nettype none

module textured_wall_column_renderer
  import twcr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: column[6:0], ray_pos_x[22:7], ray_pos_y[38:23], ray_dir_x[54:39],
  //        ray_dir_y[70:55], distance[86:71], side[87], cell_value[91:88],
  //        texel_address[106:92], texel_color[138:107], zero fill
  input  wire logic [143:0] s_axis_tdata,
  // tuser: command
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: pixel_row[5:0], pixel_column[12:6], pixel_color[44:13], zero fill
  output logic [47:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SLICE = 6'b000010,
    S_SETUP = 6'b000100,
    S_STEP  = 6'b001000,
    S_INIT  = 6'b010000,
    S_RUN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Input fields
  logic [COL_W-1:0]   in_column;
  logic [15:0]        in_pos_x, in_pos_y, in_dist;
  logic signed [15:0] in_dir_x, in_dir_y;
  logic               in_side;
  logic [3:0]         in_cell;
  logic [ADDR_W-1:0]  in_taddr;
  logic [COLOR_W-1:0] in_tcolor;

  assign in_column = s_axis_tdata[6:0];
  assign in_pos_x  = s_axis_tdata[22:7];
  assign in_pos_y  = s_axis_tdata[38:23];
  assign in_dir_x  = s_axis_tdata[54:39];
  assign in_dir_y  = s_axis_tdata[70:55];
  assign in_dist   = s_axis_tdata[86:71];
  assign in_side   = s_axis_tdata[87];
  assign in_cell   = s_axis_tdata[91:88];
  assign in_taddr  = s_axis_tdata[106:92];
  assign in_tcolor = s_axis_tdata[138:107];

  // Per-hit registers
  logic [COL_W-1:0]  column_q;
  logic              side_q;
  logic              mirror_q;
  logic [TILE_W-1:0] tile_q;
  logic [7:0]        pos_frac_q;
  logic [21:0]       prod_q;
  logic [15:0]       dist_q;
  logic [15:0]       slice_q, slice_d;
  logic [ROW_W-1:0]  y_q, y_d;
  logic [ROW_W-1:0]  bottom_q, bottom_d;
  logic [6:0]        a_q, a_d;
  logic [15:0]       b_q, b_d;
  logic [DIV_W-1:0]  q_q, q_d;
  logic [15:0]       r_q, r_d;

  // Pending texture read and output register
  logic               pend_q, pend_d;
  logic [ROW_W-1:0]   pend_row_q;
  logic               pend_last_q;
  logic               m_valid_q;
  logic [ROW_W-1:0]   m_row_q;
  logic [COL_W-1:0]   m_col_q;
  logic [COLOR_W-1:0] m_color_q;
  logic               m_last_q;

  logic               in_fire, capture, issue_ok, rd_en;
  logic               div_start;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [COLOR_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr;

  logic signed [32:0] prod_full;
  logic               hit_side, hit_mirror;
  logic [14:0]        half;
  logic [ROW_W-1:0]   top_w, bottom_w;
  logic               empty_w;
  logic [17:0]        num_w;
  logic [21:0]        hit_lo;
  logic [TEX_COL_W-1:0] tex_col;
  logic [TEX_ROW_W-1:0] tex_row;
  logic [16:0]        r_sum;
  logic               r_wrap;
  logic               last_w;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign capture  = pend_q & (~m_valid_q | m_axis_tready);
  assign issue_ok = ~pend_q | capture;
  assign rd_en    = (state_q == S_RUN) & issue_ok;
  assign s_axis_tready = (state_q == S_IDLE) & ~pend_q;

  // Hit coordinate product, registered at accept
  assign hit_side   = in_side;
  assign prod_full  = $signed({1'b0, in_dist}) * (hit_side ? in_dir_x : in_dir_y);
  assign hit_mirror = hit_side ? in_dir_y[15] : (~in_dir_x[15] & (|in_dir_x));

  // Slice extent; the row numerator is never negative for an even row count
  always_comb begin
    half     = slice_q[15:1];
    top_w    = (half >= 15'(HALF_ROWS)) ? '0
             : ROW_W'(7'(HALF_ROWS) - {1'b0, half[5:0]});
    bottom_w = (half >= 15'(HALF_ROWS - 1)) ? ROW_W'(SCREEN_ROWS - 1)
             : ROW_W'(7'(HALF_ROWS) + {2'b0, half[4:0]});
    empty_w  = top_w >= bottom_w;
    num_w    = {11'b0, top_w, 1'b0} + {2'b0, slice_q} - 18'(SCREEN_ROWS);
  end

  // Texture address of the current row
  assign hit_lo  = {pos_frac_q, 14'b0} + prod_q;
  assign tex_col = hit_lo[21:16] ^ {TEX_COL_W{mirror_q}};
  assign tex_row = (q_q >= DIV_W'(1 << TEX_ROW_W)) ? {TEX_ROW_W{1'b1}}
                 : q_q[TEX_ROW_W-1:0];
  assign raddr   = {tile_q, tex_col, tex_row};

  // Incremental texture row: quotient and remainder of the scaled numerator
  assign r_sum  = {1'b0, r_q} + {1'b0, b_q};
  assign r_wrap = r_sum >= {1'b0, slice_q};
  assign last_w = (7'(y_q) + 7'd1) == {1'b0, bottom_q};

  // Sequencer
  always_comb begin
    state_d   = state_q;
    slice_d   = slice_q;
    y_d       = y_q;
    bottom_d  = bottom_q;
    a_d       = a_q;
    b_d       = b_q;
    q_d       = q_q;
    r_d       = r_q;
    div_start = 1'b0;
    div_req.dividend = DIV_W'(SLICE_NUM);
    div_req.divisor  = in_dist;
    case (state_q)
      S_IDLE: begin
        if (in_fire && s_axis_tuser == CMD_RENDER) begin
          if (in_dist == '0) begin
            slice_d = '1;
            state_d = S_SETUP;
          end else begin
            div_start = 1'b1;
            state_d   = S_SLICE;
          end
        end
      end
      S_SLICE: begin
        if (div_rsp.done) begin
          slice_d = div_rsp.quot[15:0];
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        y_d      = top_w;
        bottom_d = bottom_w;
        div_req.dividend = DIV_W'(ROW_STEP);
        div_req.divisor  = slice_q;
        if (empty_w) begin
          state_d = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = S_STEP;
        end
      end
      S_STEP: begin
        div_req.dividend = {1'b0, num_w[16:0], 5'b0};
        div_req.divisor  = slice_q;
        if (div_rsp.done) begin
          a_d       = div_rsp.quot[6:0];
          b_d       = div_rsp.rem;
          div_start = 1'b1;
          state_d   = S_INIT;
        end
      end
      S_INIT: begin
        if (div_rsp.done) begin
          q_d     = div_rsp.quot;
          r_d     = div_rsp.rem;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (issue_ok) begin
          y_d = y_q + 1'b1;
          r_d = r_wrap ? 16'(r_sum - {1'b0, slice_q}) : r_sum[15:0];
          q_d = q_q + DIV_W'(a_q) + DIV_W'(r_wrap);
          if (last_w) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Read pending flag
  always_comb begin
    pend_d = pend_q;
    if (capture) begin
      pend_d = 1'b0;
    end
    if (rd_en) begin
      pend_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (capture) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    slice_q  <= slice_d;
    y_q      <= y_d;
    bottom_q <= bottom_d;
    a_q      <= a_d;
    b_q      <= b_d;
    q_q      <= q_d;
    r_q      <= r_d;
    if (in_fire) begin
      column_q   <= in_column;
      side_q     <= in_side;
      mirror_q   <= hit_mirror;
      tile_q     <= TILE_W'(in_cell - 4'd1);
      pos_frac_q <= hit_side ? in_pos_x[7:0] : in_pos_y[7:0];
      prod_q     <= prod_full[21:0];
      dist_q     <= in_dist;
    end
    if (rd_en) begin
      pend_row_q  <= y_q;
      pend_last_q <= last_w;
    end
    if (capture) begin
      m_row_q   <= pend_row_q;
      m_col_q   <= column_q;
      m_color_q <= side_q ? ((rdata >> 1) & SHADE_MASK) : rdata;
      m_last_q  <= pend_last_q;
    end
  end

  // Texture store
  twcr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire & (s_axis_tuser == CMD_LOAD)),
    .waddr_i (in_taddr),
    .wdata_i (in_tcolor),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared divider
  twcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {3'b0, m_color_q, m_col_q, m_row_q};

  // Checks
  `TWCR_ASSERT_NEXT(a_read_pending, rd_en, pend_q, "texture read lost")
  `TWCR_ASSERT_NEXT(a_pend_holds, pend_q && !capture, pend_q && $stable(pend_row_q),
                    "pending pixel changed while stalled")
  `TWCR_ASSERT(a_run_slice, (state_q == S_RUN) |-> (slice_q != '0 && dist_q <= 16'(SLICE_NUM)
               || dist_q == '0), "pixel run with empty slice")

endmodule

`default_nettype wire

### hdl/twcr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module twcr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/twcr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on twcr_pkg.
`default_nettype none

module twcr_div
  import twcr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DSR_W-1:0]     dsr_q, dsr_d;
  logic [DSR_W-1:0]     rem_q, rem_d;
  logic                 done_q, done_d;
  logic [DSR_W:0]       trial;
  logic                 fits;

  // Start loads the operands; otherwise one restoring step while busy
  always_comb begin
    trial  = {rem_q, dvd_q[DIV_W-1]};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
      dvd_d = {dvd_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire
